### rtl/bf_pkg.sv
// ============================================================================
// bf_pkg
// Shared sizes, codes, types and a helper for the shortest-path solver.
// ============================================================================
package bf_pkg;

    // Graph and field sizes
    localparam int MAX_VERTICES   = 32;
    localparam int WEIGHT_BITS    = 16;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int DIST_BITS      = 22;
    localparam int VERTEX_BITS    = 6;
    localparam int COUNT_BITS     = 7;
    localparam int VIDX_BITS      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EDGE_ADDR_BITS = 2 * VIDX_BITS;
    localparam int EDGE_DEPTH     = 1 << EDGE_ADDR_BITS;
    localparam int SUM_BITS       = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    // Saturation limits
    localparam longint WEIGHT_MAX_L = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
    localparam longint WEIGHT_MIN_L = -WEIGHT_MAX_L - 64'sd1;
    localparam longint DIST_MAX_L   = (64'sd1 <<< (DIST_BITS - 1)) - 64'sd1;
    localparam longint DIST_MIN_L   = -DIST_MAX_L - 64'sd1;

    // Item operation codes
    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = COUNT_BITS'(32);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_ORD,
        ST_OUT
    } bf_state_t;

    typedef struct packed {
        logic                          present;
        logic signed [WEIGHT_BITS-1:0] weight;
    } edge_entry_t;

    typedef struct packed {
        logic                      wr_en;
        logic [EDGE_ADDR_BITS-1:0] wr_addr;
        edge_entry_t               wr_data;
        logic [EDGE_ADDR_BITS-1:0] rd_addr;
    } edge_port_t;

    typedef struct packed {
        logic                        take;
        logic signed [DIST_BITS-1:0] cand;
    } relax_res_t;

    // Clamp an incoming weight to the stored weight range
    function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
        input logic signed [WEIGHT_IN_BITS-1:0] w
    );
        longint wx;
        wx = longint'(w);
        if (wx > WEIGHT_MAX_L) begin
            wx = WEIGHT_MAX_L;
        end else if (wx < WEIGHT_MIN_L) begin
            wx = WEIGHT_MIN_L;
        end
        return wx[WEIGHT_BITS-1:0];
    endfunction

endpackage

### rtl/bellman_ford_shortest_paths_top.sv
// ============================================================================
// bellman_ford_shortest_paths_top
// Single-source shortest paths from vertex 0 over an adjacency matrix.
// ============================================================================
// An edge item is written in the cycle in which it is accepted. A solve item
// runs vertex_count-1 passes; in each pass a source row that is not yet
// reachable is only loaded, and a reachable one is loaded, scanned with one
// relaxation per cycle through the shared add/compare unit, and drained.
// After the solve the n-1 results come out, each on the result ports for
// one cycle with result_strobe high; results cannot be held off. After reset
// the block clears the presence bits of all 2**(2*ceil(log2(MAX_VERTICES)))
// edge memory entries (1024 at the default size), one entry a cycle, with
// busy high.
// ============================================================================
module bellman_ford_shortest_paths_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    op,
    input  logic [bf_pkg::VERTEX_BITS-1:0]          edge_src,
    input  logic [bf_pkg::VERTEX_BITS-1:0]          edge_dst,
    input  logic signed [bf_pkg::WEIGHT_IN_BITS-1:0] edge_weight,
    input  logic                                    cfg_we,
    input  logic [bf_pkg::COUNT_BITS-1:0]           cfg_wdata,
    output logic                                    result_strobe,
    output logic [bf_pkg::VERTEX_BITS-1:0]          vertex,
    output logic                                    reachable,
    output logic signed [bf_pkg::DIST_BITS-1:0]     distance,
    output logic [bf_pkg::VERTEX_BITS-1:0]          parent,
    output logic                                    last
);
    import bf_pkg::*;

    localparam logic [EDGE_ADDR_BITS-1:0] CLR_LAST = '1;

    bf_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]  vertex_count_reg;
    logic [EDGE_ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [VIDX_BITS-1:0]   last_reg, last_next;
    logic [VIDX_BITS-1:0]   pass_reg, pass_next;
    logic [VIDX_BITS-1:0]   a_reg, a_next;
    logic [VIDX_BITS-1:0]   b_reg, b_next;
    logic                   s1_vld_reg;
    logic [VIDX_BITS-1:0]   s1_b_reg;
    logic [MAX_VERTICES-1:0] reach_reg, reach_next;
    logic signed [DIST_BITS-1:0] dist_a_reg, dist_a_next;

    logic signed [DIST_BITS-1:0] dist_mem [MAX_VERTICES];
    logic [VIDX_BITS-1:0]        parent_mem [MAX_VERTICES];
    logic signed [DIST_BITS-1:0] dist_rd_reg;
    logic [VIDX_BITS-1:0]        parent_rd_reg;

    logic                   accept;
    logic                   solve_go;
    logic                   edge_ok;
    logic [VIDX_BITS-1:0]   n_last;
    logic                   row_end;
    logic                   scan_issue;
    logic [VIDX_BITS-1:0]   tbl_rd_addr;
    edge_port_t             edge_port;
    edge_entry_t            edge_rd;
    relax_res_t             relax;

    assign accept   = start && !busy;
    assign solve_go = accept && (op == OP_SOLVE);
    assign edge_ok  = ({1'b0, edge_src} < (VERTEX_BITS + 1)'(MAX_VERTICES)) &&
                      ({1'b0, edge_dst} < (VERTEX_BITS + 1)'(MAX_VERTICES));

    // Clamp the vertex count and keep the index of the last vertex
    always_comb
    begin
        if (vertex_count_reg == '0) begin
            n_last = '0;
        end else if (vertex_count_reg > COUNT_BITS'(MAX_VERTICES)) begin
            n_last = VIDX_BITS'(MAX_VERTICES - 1);
        end else begin
            n_last = VIDX_BITS'(vertex_count_reg - COUNT_BITS'(1));
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end else if (cfg_we) begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // End of a source row: after drain, or at once when the source is unreached
    assign row_end = (state_reg == ST_DRAIN) ||
                     ((state_reg == ST_LOAD) && !reach_reg[a_reg]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (solve_go && (n_last != '0)) begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:   state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (reach_reg[a_reg]) begin
                    state_next = ST_SCAN;
                end else if ((a_reg == last_reg) &&
                             (pass_reg == last_reg - VIDX_BITS'(1))) begin
                    state_next = ST_ORD;
                end else begin
                    state_next = ST_ROW;
                end
            end
            ST_SCAN:
            begin
                if (b_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if ((a_reg == last_reg) && (pass_reg == last_reg - VIDX_BITS'(1))) begin
                    state_next = ST_ORD;
                end else begin
                    state_next = ST_ROW;
                end
            end
            ST_ORD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (b_reg == last_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_ORD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        scan_issue    = (state_reg == ST_SCAN);
        result_strobe = (state_reg == ST_OUT);
        case (state_reg)
            ST_ROW:  tbl_rd_addr = a_reg;
            default: tbl_rd_addr = b_reg;
        endcase
    end

    // Counters and indexes
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        last_next    = last_reg;
        pass_next    = pass_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (state_reg == ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + EDGE_ADDR_BITS'(1);
        end
        if ((state_reg == ST_IDLE) && solve_go) begin
            last_next = n_last;
            pass_next = '0;
            a_next    = '0;
        end
        if (state_reg == ST_LOAD) begin
            b_next = '0;
        end
        if (scan_issue && (b_reg != last_reg)) begin
            b_next = b_reg + VIDX_BITS'(1);
        end
        // Advance to the next row, the next pass or the report
        if (row_end) begin
            if (a_reg == last_reg) begin
                a_next = '0;
                if (pass_reg == last_reg - VIDX_BITS'(1)) begin
                    b_next = VIDX_BITS'(1);
                end else begin
                    pass_next = pass_reg + VIDX_BITS'(1);
                end
            end else begin
                a_next = a_reg + VIDX_BITS'(1);
            end
        end
        if ((state_reg == ST_OUT) && (b_reg != last_reg)) begin
            b_next = b_reg + VIDX_BITS'(1);
        end
    end

    // Reach bits and cached source distance
    always_comb
    begin
        reach_next  = reach_reg;
        dist_a_next = dist_a_reg;
        if ((state_reg == ST_IDLE) && solve_go) begin
            reach_next    = '0;
            reach_next[0] = 1'b1;
        end
        if (state_reg == ST_LOAD) begin
            dist_a_next = dist_rd_reg;
        end
        if (relax.take) begin
            reach_next[s1_b_reg] = 1'b1;
            if (s1_b_reg == a_reg) begin
                dist_a_next = relax.cand;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            last_reg    <= '0;
            pass_reg    <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            s1_vld_reg  <= 1'b0;
            reach_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            last_reg    <= last_next;
            pass_reg    <= pass_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            s1_vld_reg  <= scan_issue;
            reach_reg   <= reach_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_b_reg   <= b_reg;
        dist_a_reg <= dist_a_next;
    end

    // Edge memory port: clear sweep, edge writes, scan reads
    always_comb
    begin
        edge_port.rd_addr = {a_reg, b_reg};
        if (state_reg == ST_CLEAR) begin
            edge_port.wr_en           = 1'b1;
            edge_port.wr_addr         = clr_cnt_reg;
            edge_port.wr_data.present = 1'b0;
            edge_port.wr_data.weight  = '0;
        end else begin
            edge_port.wr_en           = accept && (op == OP_EDGE) && edge_ok;
            edge_port.wr_addr         = {edge_src[VIDX_BITS-1:0], edge_dst[VIDX_BITS-1:0]};
            edge_port.wr_data.present = 1'b1;
            edge_port.wr_data.weight  = sat_weight(edge_weight);
        end
    end

    bf_edge_store u_edge_store (
        .clk     (clk),
        .port    (edge_port),
        .rd_data (edge_rd)
    );

    bf_relax_unit u_relax (
        .valid     (s1_vld_reg),
        .dist_src  (dist_a_reg),
        .edge_in   (edge_rd),
        .reach_dst (reach_reg[s1_b_reg]),
        .dist_dst  (dist_rd_reg),
        .res       (relax)
    );

    // Distance and parent tables: zero the source distance at solve start,
    // write on improvement, registered read
    always_ff @(posedge clk)
    begin
        if (relax.take) begin
            dist_mem[s1_b_reg]   <= relax.cand;
            parent_mem[s1_b_reg] <= a_reg;
        end else if (solve_go) begin
            dist_mem[VIDX_BITS'(0)] <= '0;
        end
        dist_rd_reg   <= dist_mem[tbl_rd_addr];
        parent_rd_reg <= parent_mem[tbl_rd_addr];
    end

    // Result fields; distance and parent are zero for an unreached vertex
    always_comb
    begin
        vertex    = VERTEX_BITS'(b_reg);
        reachable = reach_reg[b_reg];
        distance  = reach_reg[b_reg] ? dist_rd_reg : '0;
        parent    = reach_reg[b_reg] ? VERTEX_BITS'(parent_rd_reg) : '0;
        last      = (b_reg == last_reg);
    end

    // Checks
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe && !busy)
        else $error("results continue after last item");

    a_no_vertex0: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (vertex != '0))
        else $error("result for the source vertex");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_SOLVE) && (vertex_count_reg > COUNT_BITS'(1)))
        |=> busy)
        else $error("solve accepted without going busy");

    a_src_reach: assert property (@(posedge clk) disable iff (!rst_n)
        relax.take |-> reach_reg[a_reg] && (s1_b_reg <= last_reg))
        else $error("relaxation from an unreached source");

endmodule

### rtl/bf_edge_store.sv
// ============================================================================
// bf_edge_store
// Adjacency matrix memory: one entry per (source, destination) pair holding
// a presence bit and a weight. One write port, one registered read port.
// ============================================================================
module bf_edge_store (
    input  logic                clk,
    input  bf_pkg::edge_port_t  port,
    output bf_pkg::edge_entry_t rd_data
);
    import bf_pkg::*;

    edge_entry_t mem [EDGE_DEPTH];
    edge_entry_t rd_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (port.wr_en)
        begin
            mem[port.wr_addr] <= port.wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[port.rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

### rtl/bf_relax_unit.sv
// ============================================================================
// bf_relax_unit
// Shared relaxation unit: adds an edge weight to the source distance,
// saturates to the distance range and decides whether the target improves.
// ============================================================================
module bf_relax_unit (
    input  logic                                valid,
    input  logic signed [bf_pkg::DIST_BITS-1:0] dist_src,
    input  bf_pkg::edge_entry_t                 edge_in,
    input  logic                                reach_dst,
    input  logic signed [bf_pkg::DIST_BITS-1:0] dist_dst,
    output bf_pkg::relax_res_t                  res
);
    import bf_pkg::*;

    localparam logic signed [SUM_BITS-1:0] DMAX = SUM_BITS'(DIST_MAX_L);
    localparam logic signed [SUM_BITS-1:0] DMIN = SUM_BITS'(DIST_MIN_L);

    logic signed [SUM_BITS-1:0]  dist_x;
    logic signed [SUM_BITS-1:0]  weight_x;
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [DIST_BITS-1:0] cand;

    // Add and saturate
    always_comb
    begin
        dist_x   = {{(SUM_BITS - DIST_BITS){dist_src[DIST_BITS-1]}}, dist_src};
        weight_x = {{(SUM_BITS - WEIGHT_BITS){edge_in.weight[WEIGHT_BITS-1]}},
                    edge_in.weight};
        sum      = dist_x + weight_x;
        if (sum > DMAX) begin
            cand = DMAX[DIST_BITS-1:0];
        end else if (sum < DMIN) begin
            cand = DMIN[DIST_BITS-1:0];
        end else begin
            cand = sum[DIST_BITS-1:0];
        end
    end

    // Take the candidate when the target is new or strictly improves
    always_comb
    begin
        res.cand = cand;
        res.take = valid && edge_in.present && (!reach_dst || (cand < dist_dst));
    end

endmodule
